// ----- hw/rtl/gccl_pkg.sv -----
// Shared constants and types for the grid component counter.
// Depends on nothing; used by the top module, the checker and the testbench.
package gccl_pkg;
  localparam int unsigned DefMaxCols = 1024;
  localparam int unsigned DefMaxRows = 1024;
  localparam int unsigned DimW       = 11;
  localparam int unsigned CountW     = 20;
  localparam int unsigned SizeW      = 21;

  localparam logic RegCols = 1'b0;
  localparam logic RegRows = 1'b1;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SizeW-1:0]  largest;
  } gccl_result_t;
endpackage

// ----- hw/rtl/grid_component_count_and_largest.sv -----
// Grid component counter top; uses gccl_pkg, gccl_bitmem and gccl_stack.
// Flow: one pixel per cycle while loading, unless a register write takes the
// cycle; after the last pixel, a clear pass over every cell, then a scan of
// every cell with a flood fill from each unvisited set cell, then the result word.
// One frame at a time; input not ready until the result word leaves.
// Reset (rst_ni low, async) clears control and counters and sets both dimension registers to 1024.
module grid_component_count_and_largest import gccl_pkg::*; #(
  parameter int unsigned MaxCols = DefMaxCols,
  parameter int unsigned MaxRows = DefMaxRows
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [0] pixel_set
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,   // [19:0] component_count, [40:20] largest_size
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [DimW-1:0]       cfg_data_i
);
  localparam int unsigned Cells = MaxCols * MaxRows;
  localparam int unsigned AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned CW    = $clog2(MaxCols + 1);
  localparam int unsigned RW    = $clog2(MaxRows + 1);
  localparam int unsigned NW    = $clog2(Cells + 1);
  localparam int unsigned StkW  = RW + CW + AW;

  typedef enum logic [3:0] {
    S_LOAD, S_CLEAR, S_SCAN, S_SCAN_RD, S_SCAN_CHK, S_POP, S_POP_RD,
    S_NB, S_NB_RD, S_NB_CHK, S_DONE, S_OUT
  } state_e;

  state_e state_q;
  logic [DimW-1:0] cols_reg_q, rows_reg_q;
  logic [CW-1:0]   cols;
  logic [RW-1:0]   rows;
  logic [NW-1:0]   cells, pix_q, scan_q;
  logic [NW-1:0]   sp_q;
  logic [AW-1:0]   cell_q, nb_q;
  logic [CW-1:0]   c_q;
  logic [RW-1:0]   r_q;
  logic [CW-1:0]   scan_c_q, scan_c_d, nb_c, nb_c_q;
  logic [RW-1:0]   scan_r_q, scan_r_d, nb_r, nb_r_q;
  logic [1:0]      dir_q;
  logic [SizeW-1:0]  cur_q, best_q;
  logic [CountW-1:0] found_q;
  gccl_result_t    res_q;

  // clamp dims
  always_comb begin
    if (cols_reg_q == '0) cols = CW'(1);
    else if (32'(cols_reg_q) > MaxCols) cols = CW'(MaxCols);
    else cols = CW'(cols_reg_q);
    if (rows_reg_q == '0) rows = RW'(1);
    else if (32'(rows_reg_q) > MaxRows) rows = RW'(MaxRows);
    else rows = RW'(rows_reg_q);
  end
  assign cells = NW'(cols) * NW'(rows);

  // row/col of the next scan cell
  always_comb begin
    if ((scan_c_q + CW'(1)) >= cols) begin
      scan_c_d = '0;
      scan_r_d = scan_r_q + RW'(1);
    end else begin
      scan_c_d = scan_c_q + CW'(1);
      scan_r_d = scan_r_q;
    end
  end

  // memories
  logic            img_we, vis_we, vis_wd, img_rd, vis_rd, stk_we;
  logic [AW-1:0]   img_wa, img_ra, vis_wa, vis_ra;
  logic [StkW-1:0] stk_wd, stk_rdata;
  logic [AW-1:0]   stk_wa, stk_ra;

  gccl_bitmem #(.Depth(Cells), .AddrW(AW)) u_img (
    .clk_i, .we_i(img_we), .waddr_i(img_wa), .wdata_i(s_axis_tdata[0]),
    .raddr_i(img_ra), .rdata_o(img_rd));
  gccl_bitmem #(.Depth(Cells), .AddrW(AW)) u_vis (
    .clk_i, .we_i(vis_we), .waddr_i(vis_wa), .wdata_i(vis_wd),
    .raddr_i(vis_ra), .rdata_o(vis_rd));
  gccl_stack #(.Depth(Cells), .AddrW(AW), .DataW(StkW)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rdata));

  // a register write takes the cycle; no pixel word alongside it
  assign s_axis_tready = (state_q == S_LOAD) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_LOAD);
  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  logic [NW-1:0] pix_w;
  assign pix_w = (pix_q >= cells) ? '0 : pix_q;
  assign img_we = in_acc;
  assign img_wa = AW'(pix_w);

  // neighbor selection: right, left, down, up
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  always_comb begin
    nb_ok = 1'b0;
    nb_addr = cell_q;
    nb_c = c_q;
    nb_r = r_q;
    case (dir_q)
      2'd0: begin
        nb_ok = (c_q + CW'(1)) < cols; nb_addr = cell_q + AW'(1); nb_c = c_q + CW'(1);
      end
      2'd1: begin
        nb_ok = c_q != '0; nb_addr = cell_q - AW'(1); nb_c = c_q - CW'(1);
      end
      2'd2: begin
        nb_ok = (r_q + RW'(1)) < rows; nb_addr = cell_q + AW'(cols); nb_r = r_q + RW'(1);
      end
      default: begin
        nb_ok = r_q != '0; nb_addr = cell_q - AW'(cols); nb_r = r_q - RW'(1);
      end
    endcase
  end

  // memory addressing; stack words are {row, col, cell}
  always_comb begin
    img_ra = AW'(scan_q);
    vis_ra = AW'(scan_q);
    vis_we = 1'b0;
    vis_wa = AW'(scan_q);
    vis_wd = 1'b0;
    stk_we = 1'b0;
    stk_wa = AW'(sp_q);
    stk_wd = {scan_r_q, scan_c_q, AW'(scan_q)};
    stk_ra = AW'(sp_q - NW'(1));
    case (state_q)
      S_CLEAR: vis_we = 1'b1;
      S_SCAN_CHK: begin
        if (img_rd && !vis_rd) begin
          vis_we = 1'b1; vis_wd = 1'b1; stk_we = 1'b1;
        end
      end
      S_NB: begin img_ra = nb_addr; vis_ra = nb_addr; end
      S_NB_RD: begin img_ra = nb_q; vis_ra = nb_q; end
      S_NB_CHK: begin
        if (img_rd && !vis_rd) begin
          vis_we = 1'b1; vis_wa = nb_q; vis_wd = 1'b1;
          stk_we = 1'b1; stk_wd = {nb_r_q, nb_c_q, nb_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cols_reg_q <= DimW'(1024);
      rows_reg_q <= DimW'(1024);
      pix_q <= '0; scan_q <= '0; sp_q <= '0;
      cur_q <= '0; best_q <= '0; found_q <= '0;
      dir_q <= '0; cell_q <= '0; nb_q <= '0; c_q <= '0; r_q <= '0;
      scan_c_q <= '0; scan_r_q <= '0; nb_c_q <= '0; nb_r_q <= '0;
      res_q <= '0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == RegCols) cols_reg_q <= cfg_data_i;
            else rows_reg_q <= cfg_data_i;
            pix_q <= '0;
          end else if (in_acc) begin
            if (pix_w + NW'(1) >= cells) begin
              pix_q <= '0; scan_q <= '0; state_q <= S_CLEAR;
            end else pix_q <= pix_w + NW'(1);
          end
        end
        S_CLEAR: begin
          if (scan_q + NW'(1) >= cells) begin
            scan_q <= '0; found_q <= '0; best_q <= '0; state_q <= S_SCAN;
            scan_c_q <= '0; scan_r_q <= '0;
          end else scan_q <= scan_q + NW'(1);
        end
        S_SCAN: state_q <= (scan_q >= cells) ? S_DONE : S_SCAN_RD;
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (img_rd && !vis_rd) begin
            found_q <= found_q + CountW'(1);
            cur_q <= '0; sp_q <= NW'(1); state_q <= S_POP;
          end else begin
            scan_q <= scan_q + NW'(1); state_q <= S_SCAN;
            scan_c_q <= scan_c_d; scan_r_q <= scan_r_d;
          end
        end
        S_POP: begin
          if (sp_q == '0) begin
            if (cur_q > best_q) best_q <= cur_q;
            scan_q <= scan_q + NW'(1); state_q <= S_SCAN;
            scan_c_q <= scan_c_d; scan_r_q <= scan_r_d;
          end else state_q <= S_POP_RD;
        end
        S_POP_RD: begin
          cell_q <= stk_rdata[AW-1:0];
          sp_q <= sp_q - NW'(1);
          cur_q <= cur_q + SizeW'(1);
          // row and col travel with the cell on the stack
          c_q <= stk_rdata[AW +: CW];
          r_q <= stk_rdata[AW+CW +: RW];
          dir_q <= '0;
          state_q <= S_NB;
        end
        S_NB: begin
          if (nb_ok) begin
            nb_q <= nb_addr; nb_c_q <= nb_c; nb_r_q <= nb_r; state_q <= S_NB_RD;
          end
          else if (dir_q == 2'd3) state_q <= S_POP;
          else dir_q <= dir_q + 2'd1;
        end
        S_NB_RD: state_q <= S_NB_CHK;
        S_NB_CHK: begin
          if (img_rd && !vis_rd) sp_q <= sp_q + NW'(1);
          if (dir_q == 2'd3) state_q <= S_POP;
          else begin dir_q <= dir_q + 2'd1; state_q <= S_NB; end
        end
        S_DONE: begin
          res_q.count <= found_q;
          res_q.largest <= best_q;
          state_q <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state_q <= S_LOAD;
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {7'd0, res_q.largest, res_q.count};

  ap_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> !s_axis_tready) else $error("ready while busy");
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
endmodule

// ----- hw/rtl/gccl_bitmem.sv -----
// One-bit-wide memory, one write and one registered read port per cycle.
// Depends on nothing.
module gccl_bitmem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o
);
  logic mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- hw/rtl/gccl_stack.sv -----
// Cell-address stack for the flood fill; push or pop one word a cycle.
// Depends on nothing; registered read of the popped entry.
module gccl_stack #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- dv/gccl_checker.sv -----
// Scoreboard for the grid component counter: mirrors register writes and
// pixel words, predicts each frame's result and compares output words.
// Depends on gccl_pkg for field widths and register codes.
`timescale 1ns / 1ps
module gccl_checker import gccl_pkg::*; #(
  parameter int unsigned MaxCols = DefMaxCols,
  parameter int unsigned MaxRows = DefMaxRows
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [47:0]       m_axis_tdata,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [DimW-1:0]   cfg_data_i,
  output int unsigned       mismatch_o,
  output int unsigned       pending_o
);
  localparam int unsigned CellCap = MaxCols * MaxRows;

  bit          pix_mem [CellCap];
  bit          seen_mem [CellCap];
  int unsigned walk_mem [CellCap];

  logic [DimW-1:0] cols_q, rows_q;
  int unsigned     pix_cnt_q;
  gccl_result_t    frame_results_q[$];

  assign pending_o = frame_results_q.size();

  function automatic int unsigned clamp_dim(logic [DimW-1:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic void mark_cell(int unsigned pos, inout int unsigned depth);
    if (pix_mem[pos] && !seen_mem[pos]) begin
      seen_mem[pos] = 1'b1;
      walk_mem[depth] = pos;
      depth++;
    end
  endfunction

  // Explicit-stack flood fill over the frame held in pix_mem.
  function automatic gccl_result_t label_frame(int unsigned cols, int unsigned rows);
    int unsigned cells, depth, pos, r, c, comp_size, found, best;
    gccl_result_t res;
    cells = cols * rows;
    found = 0;
    best = 0;
    for (int unsigned i = 0; i < cells; i++) seen_mem[i] = 1'b0;
    for (int unsigned s = 0; s < cells; s++) begin
      if (!pix_mem[s] || seen_mem[s]) continue;
      found++;
      comp_size = 0;
      depth = 0;
      mark_cell(s, depth);
      while (depth > 0) begin
        depth--;
        pos = walk_mem[depth];
        comp_size++;
        r = pos / cols;
        c = pos % cols;
        if (c + 1 < cols) mark_cell(pos + 1, depth);
        if (c > 0) mark_cell(pos - 1, depth);
        if (r + 1 < rows) mark_cell(pos + cols, depth);
        if (r > 0) mark_cell(pos - cols, depth);
      end
      if (comp_size > best) best = comp_size;
    end
    res.count = found[CountW-1:0];
    res.largest = best[SizeW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned cells;
    gccl_result_t want, got;
    if (!rst_ni) begin
      cols_q <= DimW'(DefMaxCols);
      rows_q <= DimW'(DefMaxRows);
      pix_cnt_q <= 0;
      mismatch_o <= 0;
      frame_results_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegCols) cols_q <= cfg_data_i;
        else if (cfg_index_i == RegRows) rows_q <= cfg_data_i;
        pix_cnt_q <= 0;
      end else if (s_axis_tvalid && s_axis_tready) begin
        cells = clamp_dim(cols_q, MaxCols) * clamp_dim(rows_q, MaxRows);
        pix_mem[pix_cnt_q] = s_axis_tdata[0];
        if (pix_cnt_q + 1 >= cells) begin
          pix_cnt_q <= 0;
          frame_results_q.push_back(label_frame(clamp_dim(cols_q, MaxCols),
                                                clamp_dim(rows_q, MaxRows)));
        end else begin
          pix_cnt_q <= pix_cnt_q + 1;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.count = m_axis_tdata[19:0];
        got.largest = m_axis_tdata[40:20];
        if (frame_results_q.size() == 0) begin
          if (mismatch_o < 10) $display("ERROR: unexpected result word count=%0d largest=%0d",
                                        got.count, got.largest);
          mismatch_o <= mismatch_o + 1;
        end else begin
          want = frame_results_q.pop_front();
          if (got.count !== want.count || got.largest !== want.largest) begin
            if (mismatch_o < 10)
              $display("ERROR: result mismatch exp count=%0d largest=%0d got count=%0d largest=%0d",
                       want.count, want.largest, got.count, got.largest);
            mismatch_o <= mismatch_o + 1;
          end
        end
      end
    end
  end
endmodule

// ----- dv/tb_grid_component_count_and_largest.sv -----
// Testbench top for the grid component counter: clock, reset, pixel and
// register stimulus, output backpressure, watchdog and verdict.
// Depends on gccl_pkg, gccl_checker and the block itself.
`timescale 1ns / 1ps
module tb_grid_component_count_and_largest;
  import gccl_pkg::*;

  localparam int unsigned IdleLimit = 3000000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [47:0]     m_axis_tdata;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic            cfg_index_i = RegCols;
  logic [DimW-1:0] cfg_data_i = '0;

  int unsigned mismatches, pending;
  int unsigned tx_idle = 14, rx_idle = 51;
  int unsigned hold_len = 0;
  bit          hold_on = 1'b0;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  grid_component_count_and_largest dut (.*);

  gccl_checker scoreboard (.*, .mismatch_o(mismatches), .pending_o(pending));

  // Receiver: random stalls, or a solid hold-off while hold_on is set.
  always @(posedge clk_i) begin
    if (!rst_ni || hold_on) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
  end

  initial forever begin
    wait (hold_len != 0);
    hold_on = 1'b1;
    repeat (hold_len) @(posedge clk_i);
    hold_on = 1'b0;
    hold_len = 0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sender keeps tvalid high across back-to-back words; gaps are random.
  task automatic send_pixel(bit px);
    bit ok;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, px};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    if ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // partial frames produce no word, so give the block time to settle
    repeat (50) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_reg(logic idx, logic [DimW-1:0] val);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
  endtask

  task automatic set_dims(logic [DimW-1:0] cols, logic [DimW-1:0] rows);
    drain();
    write_reg(RegCols, cols);
    write_reg(RegRows, rows);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_frame(int unsigned cells, int unsigned density);
    for (int unsigned i = 0; i < cells; i++) send_pixel($urandom_range(0, 99) < density);
  endtask

  task automatic random_phase(int unsigned budget);
    int unsigned sent, cols, rows, density;
    sent = 0;
    while (sent < budget) begin
      cols = $urandom_range(1, 7);
      rows = $urandom_range(1, 7);
      if ($urandom_range(0, 9) == 0) cols = 0;
      if ($urandom_range(0, 9) == 0) rows = 0;
      set_dims(DimW'(cols), DimW'(rows));
      cols = (cols == 0) ? 1 : cols;
      rows = (rows == 0) ? 1 : rows;
      repeat ($urandom_range(1, 3)) begin
        density = $urandom_range(0, 4) * 25;
        send_frame(cols * rows, density);
        sent += cols * rows;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: checkerboard, single pixels, zero-size clamp, mid-frame write
    set_dims(DimW'(3), DimW'(3));
    for (int i = 0; i < 9; i++) send_pixel(i % 2 == 0);
    set_dims(DimW'(1), DimW'(1));
    send_pixel(1'b1);
    send_pixel(1'b0);
    set_dims(DimW'(0), DimW'(0));
    send_pixel(1'b1);
    set_dims(DimW'(3), DimW'(2));
    repeat (4) send_pixel(1'b1);
    drain();
    write_reg(RegCols, DimW'(2));
    cfg_valid_i <= 1'b0;
    repeat (4) send_pixel(1'b1);

    random_phase(140);

    // backpressure: receiver holds while further frames are offered
    set_dims(DimW'(2), DimW'(2));
    hold_len = 2000;
    send_frame(12, 60);
    drain();

    tx_idle = 51;
    rx_idle = 14;
    random_phase(140);

    tx_idle = 0;
    rx_idle = 0;
    random_phase(140);
    // one wide row and one tall column
    set_dims(DimW'(64), DimW'(1));
    send_frame(64, 70);
    set_dims(DimW'(1), DimW'(64));
    send_frame(64, 70);

    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/gccl_pkg.sv
hw/rtl/gccl_bitmem.sv
hw/rtl/gccl_stack.sv
hw/rtl/grid_component_count_and_largest.sv
dv/gccl_checker.sv
dv/tb_grid_component_count_and_largest.sv
